[src/fred_pkg.sv]
`timescale 1ns / 1ps
package fred_pkg;

  localparam int MAX_FRAME_SAMPLES = 4096;
  localparam int MAX_GROUP = 1024;

  localparam int RAW_W = 16;
  localparam int AMP_W = 7;
  localparam int MODE_W = 2;
  localparam int GS_W = 11;
  localparam int IDX_W = 2;
  localparam int FS_W = 15;

  // Frame energy: squares of at most 2^15 summed over the frame.
  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = 31 + $clog2(MAX_FRAME_SAMPLES);
  localparam int PROD_W = AMP_W + FS_W;
  localparam int SQ_W = 2 * PROD_W;
  localparam int SCALE_W = 14;
  localparam int RHS_W = SUM_W + SCALE_W;
  localparam int T_W = SQ_W + CNT_W;
  localparam int CMP_W = (RHS_W > T_W) ? RHS_W : T_W;

  localparam int GCNT_W = $clog2(MAX_GROUP + 1);
  localparam int PHASE_W = $clog2(MAX_GROUP);
  localparam int TOT_W = $clog2(100 * MAX_GROUP + 1);
  localparam int DCNT_W = $clog2(TOT_W);

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd3;

  localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_FORMAT = 2'd1;
  localparam logic [IDX_W-1:0] REG_GROUP  = 2'd2;

  localparam logic FMT_U8  = 1'b0;
  localparam logic FMT_S16 = 1'b1;

  localparam logic [AMP_W-1:0] AMP_MAX = 7'd100;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MUL_A,
    S_MUL_SQ,
    S_MUL_N,
    S_CMP,
    S_DECIM,
    S_DIV,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic acc;
    logic setup;
    logic mul_a;
    logic mul_sq;
    logic mul_n;
    logic cmp;
    logic decim;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic emit;
    logic need_div;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

[src/fred_ctrl.sv]
`timescale 1ns / 1ps
module fred_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          frame_end,
  output logic          in_ready,
  input  fred_pkg::stat_t stat,
  output fred_pkg::cmd_t  cmd
);
  import fred_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && frame_end) state_next = S_SETUP;
      end
      S_SETUP:  state_next = S_MUL_A;
      S_MUL_A:  state_next = S_MUL_SQ;
      S_MUL_SQ: state_next = S_MUL_N;
      S_MUL_N:  state_next = S_CMP;
      S_CMP: begin
        state_next = stat.last_bit ? S_DECIM : S_MUL_A;
      end
      S_DECIM: begin
        if (!stat.emit) state_next = S_IDLE;
        else if (stat.need_div) state_next = S_DIV;
        else state_next = S_PUSH;
      end
      S_DIV: begin
        if (stat.div_last) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        cmd.acc = in_valid && !rst;
      end
      S_SETUP:  cmd.setup = 1'b1;
      S_MUL_A:  cmd.mul_a = 1'b1;
      S_MUL_SQ: cmd.mul_sq = 1'b1;
      S_MUL_N:  cmd.mul_n = 1'b1;
      S_CMP:    cmd.cmp = 1'b1;
      S_DECIM:  cmd.decim = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_PUSH:   cmd.push = stat.out_free;
      default: ;
    endcase
  end

endmodule

[src/fred_dp.sv]
`timescale 1ns / 1ps
module fred_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fred_pkg::RAW_W-1:0]   sample_bits,
  input  logic                         cfg_valid,
  input  logic [fred_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fred_pkg::GS_W-1:0]    cfg_data,
  input  fred_pkg::cmd_t               cmd,
  output fred_pkg::stat_t              stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fred_pkg::AMP_W-1:0]   amplitude
);
  import fred_pkg::*;

  logic [MODE_W-1:0] mode;
  logic              fmt;
  logic [GS_W-1:0]   gsize;

  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt;

  logic [RHS_W-1:0]  rhs;
  logic [CNT_W-1:0]  n_lat;
  logic [FS_W-1:0]   fs_lat;
  logic [2:0]        bit_idx;
  logic [AMP_W-1:0]  a_res;
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq;
  logic [T_W-1:0]    tval;

  logic [PHASE_W-1:0] phase;
  logic [AMP_W-1:0]   g_first;
  logic [AMP_W-1:0]   g_min;
  logic [TOT_W-1:0]   g_total;
  logic [GCNT_W-1:0]  g_count;

  logic [GCNT_W-1:0] div_rem;
  logic [TOT_W-1:0]  div_q;
  logic [GCNT_W-1:0] divisor;
  logic [DCNT_W-1:0] div_cnt;
  logic [AMP_W-1:0]  res;

  // Sample magnitude and its square.
  logic signed [RAW_W:0] v17;
  logic [RAW_W-1:0]      mag;
  logic [2*RAW_W-1:0]    mag_sq;

  always_comb begin
    if (fmt == FMT_U8) v17 = signed'((RAW_W+1)'(sample_bits[7:0])) - 17'sd127;
    else v17 = signed'({sample_bits[RAW_W-1], sample_bits});
    mag = v17[RAW_W] ? RAW_W'(-v17) : v17[RAW_W-1:0];
    mag_sq = mag * mag;
  end

  // Root search: one trial bit per pass through the multiply chain.
  logic [AMP_W-1:0] trial;
  logic             trial_ok;
  assign trial = a_res | AMP_W'(7'd1 << bit_idx);
  assign trial_ok = (trial <= AMP_MAX) && (CMP_W'(tval) <= CMP_W'(rhs));

  // Group update for the finished frame.
  logic [AMP_W-1:0]  first_n, min_n;
  logic [TOT_W-1:0]  tot_n;
  logic [GCNT_W-1:0] count_n;
  logic [GCNT_W-1:0] gs_eff;
  logic [GCNT_W-1:0] phase_inc;

  always_comb begin
    first_n = (g_count == '0) ? a_res : g_first;
    min_n = (a_res < g_min) ? a_res : g_min;
    tot_n = g_total + TOT_W'(a_res);
    count_n = g_count + GCNT_W'(1);
    if (int'(gsize) < 2) gs_eff = GCNT_W'(2);
    else if (int'(gsize) > MAX_GROUP) gs_eff = GCNT_W'(MAX_GROUP);
    else gs_eff = GCNT_W'(gsize);
    phase_inc = GCNT_W'(phase) + GCNT_W'(1);
  end

  // Restoring divider for the group mean.
  logic [GCNT_W:0]   d_trial;
  logic              d_ge;
  logic [GCNT_W-1:0] rem_n;
  logic [TOT_W-1:0]  q_n;

  always_comb begin
    d_trial = {div_rem, div_q[TOT_W-1]};
    d_ge = d_trial >= {1'b0, divisor};
    rem_n = d_ge ? GCNT_W'(d_trial - {1'b0, divisor}) : d_trial[GCNT_W-1:0];
    q_n = {div_q[TOT_W-2:0], d_ge};
  end

  always_comb begin
    stat.last_bit = (bit_idx == 3'd0);
    stat.emit = (mode == MODE_NONE) || (phase == '0);
    stat.need_div = (mode == MODE_MEAN) && (phase == '0);
    stat.div_last = (div_cnt == DCNT_W'(TOT_W - 1));
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
      fmt <= FMT_S16;
      gsize <= GS_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode <= cfg_data[MODE_W-1:0];
        REG_FORMAT: fmt <= cfg_data[0];
        REG_GROUP:  gsize <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      cnt <= '0;
    end else if (cmd.acc) begin
      if (int'(cnt) < MAX_FRAME_SAMPLES) begin
        sum <= sum + SUM_W'(mag_sq);
        cnt <= cnt + CNT_W'(1);
      end
    end else if (cmd.setup) begin
      sum <= '0;
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rhs <= RHS_W'(sum) * RHS_W'(10000);
      n_lat <= cnt;
      fs_lat <= (fmt == FMT_U8) ? FS_W'(127) : FS_W'(32767);
      bit_idx <= 3'd6;
      a_res <= '0;
    end
    if (cmd.mul_a) prod <= trial * fs_lat;
    if (cmd.mul_sq) sq <= prod * prod;
    if (cmd.mul_n) tval <= sq * n_lat;
    if (cmd.cmp) begin
      if (trial_ok) a_res <= trial;
      bit_idx <= bit_idx - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      g_first <= '0;
      g_min <= '1;
      g_total <= '0;
      g_count <= '0;
    end else if (cmd.decim) begin
      if (stat.emit) begin
        g_first <= '0;
        g_min <= '1;
        g_total <= '0;
        g_count <= '0;
      end else begin
        g_first <= first_n;
        g_min <= min_n;
        g_total <= tot_n;
        g_count <= count_n;
      end
      if (phase_inc >= gs_eff) phase <= '0;
      else phase <= phase_inc[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decim) begin
      priority case (mode)
        MODE_FIRST: res <= first_n;
        MODE_MIN:   res <= min_n;
        default:    res <= a_res;
      endcase
      div_q <= tot_n;
      div_rem <= '0;
      divisor <= count_n;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q <= q_n;
      div_rem <= rem_n;
      div_cnt <= div_cnt + DCNT_W'(1);
      if (stat.div_last) res <= q_n[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) amplitude <= res;
  end

  a_amp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> amplitude <= AMP_MAX)
    else $error("amplitude above full scale");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid && amplitude == $past(res))
    else $error("pushed word not presented");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    int'(g_count) <= MAX_GROUP && int'(phase) < MAX_GROUP)
    else $error("group bookkeeping out of range");

endmodule

[src/frame_rms_envelope_decimator_top.sv]
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in       in_valid / in_ready     sample_bits[15:0], frame_end
// out      out_valid / out_ready   amplitude[6:0]
// cfg      cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[10:0]
//
// A word without frame_end is only accumulated. A frame-closing word passes
// through the accepting cycle, a setup state, seven passes of the shared
// multiply chain (MUL_A, MUL_SQ, MUL_N, CMP) that find the root bit by bit,
// a decimation state and, when it produces a result, a push state that loads
// the output register. Truncated-mean results first run the serial divider.
// Reset is synchronous; the configuration is ready whenever reset is low, and
// the output register holds a result while new words are taken, stalling only
// a closing frame whose result cannot yet be loaded.
module frame_rms_envelope_decimator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fred_pkg::RAW_W-1:0]  sample_bits,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fred_pkg::AMP_W-1:0]  amplitude,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fred_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fred_pkg::GS_W-1:0]   cfg_data
);
  import fred_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !rst;

  fred_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .frame_end(frame_end),
    .in_ready(in_ready),
    .stat(stat),
    .cmd(cmd)
  );

  fred_dp u_dp (
    .clk(clk),
    .rst(rst),
    .sample_bits(sample_bits),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .amplitude(amplitude)
  );

endmodule
